// ===== design/sqe_pkg.sv =====
package sqe_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int VALUE_W  = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DUMP = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SWAP = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BADARG     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PEEK_EMPTY = 3'd2;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SWAP_SHORT = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;

    typedef enum logic [1:0] {
        RD_TOP  = 2'd0,
        RD_NEXT = 2'd1,
        RD_IDX  = 2'd2
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_PUSH   = 2'd0,
        WR_SWAP_A = 2'd1,
        WR_SWAP_B = 2'd2
    } wr_sel_t;

    // controller to datapath
    typedef struct packed {
        logic                capture;
        logic                rd_en;
        rd_sel_t             rd_sel;
        logic                wr_en;
        wr_sel_t             wr_sel;
        logic                push_upd;
        logic                pop_upd;
        logic                hold_cap;
        logic                idx_inc;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
        logic                out_dvalid;
        logic                out_last;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             bad;
        logic             empty;
        logic             full;
        logic             lt_two;
        logic             dump_last;
        logic             out_free;
    } sts_t;

endpackage

// ===== design/stack_queue_engine.sv =====
// Channel  Direction  Handshake            Payload
// s_*      in         s_tvalid / s_tready  s_tdata: push_value; s_tuser: cmd, arg_bad
// m_*      out        m_tvalid / m_tready  m_tdata: data_out; m_tuser: status, data_valid;
//                                          m_tlast: last
// cfg_*    in         cfg_we               cfg_wdata: queue_mode
//
// One command at a time, held by the controller. Swap makes two reads and two
// writes on the single write port of the entry RAM; a dump makes one registered
// RAM read per entry. Reset empties the store at once; no clearing pass. A
// stalled output holds each step that loads a result; a new command is taken
// while the last result still waits in the output register.
module stack_queue_engine #(
    parameter int DEPTH = sqe_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] push_value
    input  logic [3:0]  s_tuser,   // [2:0] cmd, [3] arg_bad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] data_out
    output logic [3:0]  m_tuser,   // [2:0] status, [3] data_valid
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_wdata  // queue_mode
);

    sqe_pkg::ctl_t ctl;
    sqe_pkg::sts_t sts;

    sqe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    sqe_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule

// ===== design/sqe_ram.sv =====
module sqe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/sqe_datapath.sv =====
module sqe_datapath #(
    parameter int DEPTH = sqe_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    input  logic [31:0]                   s_tdata,
    input  logic [3:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,
    output logic [3:0]                    m_tuser,
    output logic                          m_tlast,
    input  sqe_pkg::ctl_t                 ctl,
    output sqe_pkg::sts_t                 sts
);

    localparam int PW = $clog2(DEPTH);
    localparam int SW = PW + 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [PW-1:0]                   top_reg, top_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [PW-1:0]                   idx_reg, idx_next;
    logic                            mode_reg;
    logic [sqe_pkg::CMD_W-1:0]       cmd_reg;
    logic [sqe_pkg::VALUE_W-1:0]     val_reg;
    logic                            bad_reg;
    logic [sqe_pkg::VALUE_W-1:0]     hold_reg;

    logic                            m_valid_reg, m_valid_next;
    logic [sqe_pkg::STATUS_W-1:0]    m_status_reg;
    logic [sqe_pkg::VALUE_W-1:0]     m_data_reg;
    logic                            m_dvalid_reg;
    logic                            m_last_reg;

    logic                            stack_push;
    logic [PW-1:0]                   top_dec;
    logic [PW-1:0]                   next_slot;
    logic [PW-1:0]                   idx_slot;
    logic [PW-1:0]                   tail_slot;
    logic [PW-1:0]                   push_addr;
    logic                            out_free;

    logic                            ram_wr_en;
    logic [PW-1:0]                   ram_wr_addr;
    logic [sqe_pkg::VALUE_W-1:0]     ram_wr_data;
    logic [PW-1:0]                   ram_rd_addr;
    logic [sqe_pkg::VALUE_W-1:0]     ram_rd_data;

    // offset sums stay below twice the depth: one compare and subtract
    function automatic logic [PW-1:0] wrap(input logic [SW-1:0] s);
        logic [SW-1:0] d;
        d = s - SW'(DEPTH);
        if (s >= SW'(DEPTH))
        begin
            return d[PW-1:0];
        end
        return s[PW-1:0];
    endfunction

    assign stack_push = !mode_reg || (count_reg == '0);
    assign top_dec    = (top_reg == '0) ? PW'(DEPTH - 1) : top_reg - PW'(1);
    assign next_slot  = wrap({1'b0, top_reg} + SW'(1));
    assign idx_slot   = wrap({1'b0, top_reg} + SW'(idx_reg));
    assign tail_slot  = wrap({1'b0, top_reg} + SW'(count_reg));
    assign push_addr  = stack_push ? top_dec : tail_slot;
    assign out_free   = !m_valid_reg || m_tready;

    always_comb
    begin
        top_next   = top_reg;
        count_next = count_reg;
        if (ctl.push_upd)
        begin
            if (stack_push)
            begin
                top_next = top_dec;
            end
            count_next = count_reg + CW'(1);
        end
        else if (ctl.pop_upd)
        begin
            top_next   = next_slot;
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (ctl.capture)
        begin
            idx_next = '0;
        end
        else if (ctl.idx_inc)
        begin
            idx_next = idx_reg + PW'(1);
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (ctl.out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        unique case (ctl.rd_sel)
            sqe_pkg::RD_TOP:  ram_rd_addr = top_reg;
            sqe_pkg::RD_NEXT: ram_rd_addr = next_slot;
            sqe_pkg::RD_IDX:  ram_rd_addr = idx_slot;
            default:          ram_rd_addr = top_reg;
        endcase
    end

    always_comb
    begin
        ram_wr_en = ctl.wr_en;
        unique case (ctl.wr_sel)
            sqe_pkg::WR_PUSH:
            begin
                ram_wr_addr = push_addr;
                ram_wr_data = val_reg;
            end
            sqe_pkg::WR_SWAP_A:
            begin
                ram_wr_addr = top_reg;
                ram_wr_data = ram_rd_data;
            end
            sqe_pkg::WR_SWAP_B:
            begin
                ram_wr_addr = next_slot;
                ram_wr_data = hold_reg;
            end
            default:
            begin
                ram_wr_addr = push_addr;
                ram_wr_data = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg     <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            mode_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            top_reg     <= top_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            val_reg <= s_tdata;
            cmd_reg <= s_tuser[2:0];
            bad_reg <= s_tuser[3];
        end
        if (ctl.hold_cap)
        begin
            hold_reg <= ram_rd_data;
        end
        if (ctl.out_load)
        begin
            m_status_reg <= ctl.out_status;
            m_dvalid_reg <= ctl.out_dvalid;
            m_last_reg   <= ctl.out_last;
            m_data_reg   <= ctl.out_dvalid ? ram_rd_data : '0;
        end
    end

    sqe_ram #(
        .WIDTH (sqe_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ctl.rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign sts.cmd       = cmd_reg;
    assign sts.bad       = bad_reg;
    assign sts.empty     = (count_reg == '0);
    assign sts.full      = (count_reg == CW'(DEPTH));
    assign sts.lt_two    = (count_reg < CW'(2));
    assign sts.dump_last = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign sts.out_free  = out_free;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = {m_dvalid_reg, m_status_reg};
    assign m_tlast  = m_last_reg;

endmodule

// ===== design/sqe_ctrl.sv =====
module sqe_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  sqe_pkg::sts_t sts,
    output sqe_pkg::ctl_t ctl
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DECODE   = 8'b0000_0010,
        S_PEEK_OUT = 8'b0000_0100,
        S_DUMP_RD  = 8'b0000_1000,
        S_DUMP_OUT = 8'b0001_0000,
        S_SWAP_RB  = 8'b0010_0000,
        S_SWAP_WA  = 8'b0100_0000,
        S_SWAP_WB  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        ctl            = '0;
        ctl.rd_sel     = sqe_pkg::RD_TOP;
        ctl.wr_sel     = sqe_pkg::WR_PUSH;
        ctl.out_status = sqe_pkg::ST_OK;
        ctl.out_last   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE:
            begin
                unique case (sts.cmd)
                    sqe_pkg::CMD_PUSH:
                    begin
                        if (sts.out_free)
                        begin
                            ctl.out_load = 1'b1;
                            if (sts.bad)
                            begin
                                ctl.out_status = sqe_pkg::ST_BADARG;
                            end
                            else if (sts.full)
                            begin
                                ctl.out_status = sqe_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctl.wr_en    = 1'b1;
                                ctl.push_upd = 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    sqe_pkg::CMD_DUMP:
                    begin
                        if (!sts.empty)
                        begin
                            ctl.rd_en  = 1'b1;
                            ctl.rd_sel = sqe_pkg::RD_IDX;
                            state_next = S_DUMP_OUT;
                        end
                        else if (sts.out_free)
                        begin
                            ctl.out_load = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                    sqe_pkg::CMD_PEEK:
                    begin
                        if (!sts.empty)
                        begin
                            ctl.rd_en  = 1'b1;
                            state_next = S_PEEK_OUT;
                        end
                        else if (sts.out_free)
                        begin
                            ctl.out_load   = 1'b1;
                            ctl.out_status = sqe_pkg::ST_PEEK_EMPTY;
                            state_next     = S_IDLE;
                        end
                    end
                    sqe_pkg::CMD_POP:
                    begin
                        if (sts.out_free)
                        begin
                            ctl.out_load = 1'b1;
                            if (sts.empty)
                            begin
                                ctl.out_status = sqe_pkg::ST_POP_EMPTY;
                            end
                            else
                            begin
                                ctl.pop_upd = 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    sqe_pkg::CMD_SWAP:
                    begin
                        if (!sts.lt_two)
                        begin
                            ctl.rd_en  = 1'b1;
                            state_next = S_SWAP_RB;
                        end
                        else if (sts.out_free)
                        begin
                            ctl.out_load   = 1'b1;
                            ctl.out_status = sqe_pkg::ST_SWAP_SHORT;
                            state_next     = S_IDLE;
                        end
                    end
                    default:
                    begin
                        // unknown command: plain ok result
                        if (sts.out_free)
                        begin
                            ctl.out_load = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                endcase
            end

            S_PEEK_OUT:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load   = 1'b1;
                    ctl.out_dvalid = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_DUMP_RD:
            begin
                ctl.rd_en  = 1'b1;
                ctl.rd_sel = sqe_pkg::RD_IDX;
                state_next = S_DUMP_OUT;
            end

            S_DUMP_OUT:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load   = 1'b1;
                    ctl.out_dvalid = 1'b1;
                    ctl.out_last   = sts.dump_last;
                    if (sts.dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctl.idx_inc = 1'b1;
                        state_next  = S_DUMP_RD;
                    end
                end
            end

            S_SWAP_RB:
            begin
                // hold the top word, fetch the one below
                ctl.hold_cap = 1'b1;
                ctl.rd_en    = 1'b1;
                ctl.rd_sel   = sqe_pkg::RD_NEXT;
                state_next   = S_SWAP_WA;
            end

            S_SWAP_WA:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_sel = sqe_pkg::WR_SWAP_A;
                state_next = S_SWAP_WB;
            end

            S_SWAP_WB:
            begin
                if (sts.out_free)
                begin
                    ctl.wr_en    = 1'b1;
                    ctl.wr_sel   = sqe_pkg::WR_SWAP_B;
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
